/* src/osvf_pkg.sv */
package osvf_pkg;

    localparam int AUDIO_W = 24;
    localparam int FC_W    = 17;
    localparam int Q_W     = 18;
    localparam int COEF_W  = 18;
    localparam int ST_W    = 32;

    localparam logic signed [19:0] DAMP_BASE     = 20'sd64881;
    localparam logic signed [19:0] DAMP_MAX      = 20'sd45875;
    localparam logic signed [19:0] DAMP_MIN      = -20'sd655;
    localparam logic signed [19:0] SMOOTH_OFFSET = 20'sd1311;
    localparam logic [15:0]        SMOOTH_GAIN   = 16'd40000;
    localparam logic [29:0]        PI_QUARTER_Q30 = 30'd843314857;
    localparam logic [16:0]        COEF_MAX      = 17'd131071;
    // 2^34 / 6 rounded up: (x * RECIP6) >> 34 is x / 6 for any 32-bit x
    localparam logic [31:0]        RECIP6        = 32'hAAAA_AAAB;

    localparam logic [1:0] MODE_LOW  = 2'd0;
    localparam logic [1:0] MODE_HIGH = 2'd1;
    localparam logic [1:0] MODE_BAND = 2'd2;
    localparam logic [1:0] MODE_NOTCH = 2'd3;

    localparam logic [2:0] CFG_MODE   = 3'd0;
    localparam logic [2:0] CFG_CUTOFF = 3'd1;
    localparam logic [2:0] CFG_RES    = 3'd2;
    localparam logic [2:0] CFG_FC_IN  = 3'd3;
    localparam logic [2:0] CFG_Q_IN   = 3'd4;
    localparam logic [2:0] CFG_SR     = 3'd5;
    localparam logic [2:0] CFG_INV_SR = 3'd6;

    // word handed from front to back
    typedef struct packed {
        logic signed [AUDIO_W-1:0] audio;
        logic [FC_W-1:0]           fc;
        logic signed [Q_W-1:0]     q;
        logic                      upd;
    } job_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_C_R, ST_C_X, ST_C_X2, ST_C_X3, ST_C_S,
        ST_C_QC1, ST_C_QC2,
        ST_SMOOTH,
        ST_L1, ST_D1, ST_H1, ST_B1,
        ST_L2, ST_D2, ST_H2, ST_B2,
        ST_CU1, ST_CU2, ST_CU3, ST_CU4,
        ST_OUT
    } state_t;

    function automatic logic signed [ST_W-1:0] sat32(input logic signed [47:0] v);
        if (v > 48'sh0000_7FFF_FFFF)
            return 32'sh7FFF_FFFF;
        else if (v < -48'sh0000_8000_0000)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

endpackage

/* src/osvf_front.sv */
module osvf_front
    import osvf_pkg::*;
#(
    parameter int UPD_LOG2 = 4
)(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic signed [AUDIO_W-1:0] audio_in,
    input  logic [FC_W-1:0]           cutoff_in,
    input  logic signed [Q_W-1:0]     resonance_in,
    input  logic                      modulated,
    output logic                      job_valid,
    output job_t                      job,
    input  logic                      job_take
);

    localparam int PH_W = (UPD_LOG2 > 0) ? UPD_LOG2 : 1;

    logic [PH_W-1:0] phase_reg;
    job_t            q_reg [2];
    logic            wr_reg, rd_reg;
    logic [1:0]      cnt_reg;
    logic            acc;
    logic            upd;

    assign full      = (cnt_reg == 2'd2);
    assign acc       = push && !full;
    assign job_valid = (cnt_reg != 2'd0);
    assign job       = q_reg[rd_reg];

    // classify: coefficient refresh on this word or not
    always_comb
    begin
        if (UPD_LOG2 == 0)
            upd = 1'b1;
        else
            upd = !modulated || (phase_reg == '0);
    end

    // phase counter and two-entry queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            wr_reg    <= 1'b0;
            rd_reg    <= 1'b0;
            cnt_reg   <= 2'd0;
        end
        else
        begin
            if (acc)
            begin
                if (UPD_LOG2 > 0)
                    phase_reg <= phase_reg + 1'b1;
                wr_reg <= !wr_reg;
            end
            if (job_take && job_valid)
                rd_reg <= !rd_reg;
            cnt_reg <= cnt_reg + {1'b0, acc} - {1'b0, job_take && job_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
            q_reg[wr_reg] <= '{audio: audio_in, fc: cutoff_in, q: resonance_in, upd: upd};
    end

endmodule

/* src/osvf_back.sv */
module osvf_back
    import osvf_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      job_valid,
    input  job_t                      job,
    output logic                      job_take,
    input  logic [1:0]                filter_mode,
    input  logic [FC_W-1:0]           cutoff_hz,
    input  logic signed [Q_W-1:0]     resonance,
    input  logic                      cutoff_from_input,
    input  logic                      resonance_from_input,
    input  logic [17:0]               sample_rate_hz,
    input  logic [31:0]               inv_sample_rate,
    output logic                      empty,
    input  logic                      pop,
    output logic signed [AUDIO_W-1:0] audio_out
);

    state_t state_reg, state_next;
    job_t   cur_reg;
    logic signed [ST_W-1:0] l_reg, b_reg, m_reg, h_reg, t_reg;
    logic signed [COEF_W-1:0] f_reg, d_reg, qc_reg;
    logic [63:0] acc_reg;
    logic [31:0] x_reg;
    logic signed [AUDIO_W-1:0] out_reg;
    logic out_v_reg;
    logic neg_reg;

    // shared multiplier
    logic signed [33:0] ma, mb;
    logic signed [67:0] prod;
    assign prod = ma * mb;

    logic [18:0] f2;
    logic [FC_W-1:0] fc_sel;
    logic signed [Q_W-1:0] q_sel;
    logic signed [19:0] lq;
    logic signed [ST_W-1:0] b_new;
    logic signed [47:0] sum, y_sh;
    logic [63:0] pu;

    assign fc_sel = cutoff_from_input ? job.fc : cutoff_hz;
    assign q_sel  = resonance_from_input ? job.q : resonance;
    assign f2     = ({2'b0, fc_sel} << 1) > {1'b0, sample_rate_hz}
                    ? {1'b0, sample_rate_hz} : {1'b0, fc_sel, 1'b0};
    assign pu     = prod[63:0];
    assign b_new  = sat32(48'(b_reg) + 48'(prod >>> 16));

    always_comb
    begin
        lq = DAMP_BASE - 20'(q_sel);
        if (lq > DAMP_MAX) lq = DAMP_MAX;
        if (lq < DAMP_MIN) lq = DAMP_MIN;
    end

    // output response select
    always_comb
    begin
        unique case (filter_mode)
            MODE_LOW:  sum = 48'(l_reg);
            MODE_HIGH: sum = 48'(h_reg);
            MODE_BAND: sum = 48'(b_reg);
            default:   sum = 48'(h_reg) + 48'(l_reg);
        endcase
    end
    assign y_sh = sum >>> 5;

    assign empty     = !out_v_reg;
    assign audio_out = out_reg;
    assign job_take  = (state_reg == ST_OUT) && !out_v_reg;

    // multiplier operand select
    always_comb
    begin
        ma  = '0;
        mb  = '0;
        unique case (state_reg)
            ST_C_R:   begin ma = 34'(f2);          mb = 34'(inv_sample_rate); end
            ST_C_X:   begin ma = 34'(acc_reg[31:0]); mb = 34'(PI_QUARTER_Q30); end
            ST_C_X2:  begin ma = 34'(x_reg);       mb = 34'(x_reg); end
            ST_C_X3:  begin ma = 34'(acc_reg[31:0]); mb = 34'(x_reg); end
            ST_C_S:   begin ma = 34'(acc_reg[31:0]); mb = 34'(RECIP6); end
            ST_C_QC1: begin ma = 34'(d_reg + 18'(SMOOTH_OFFSET)); mb = 34'(SMOOTH_GAIN); end
            ST_C_QC2: begin ma = 34'(acc_reg[31:0]); mb = 34'(inv_sample_rate); end
            ST_SMOOTH:
            begin
                ma = 34'(qc_reg);
                mb = 34'sd32 * 34'(job.audio) - 34'(m_reg);
            end
            ST_L1, ST_L2: begin ma = 34'(f_reg); mb = 34'(b_reg); end
            ST_D1, ST_D2: begin ma = 34'(d_reg); mb = 34'(b_reg); end
            ST_B1, ST_B2: begin ma = 34'(f_reg); mb = 34'(h_reg); end
            // magnitude is taken unsigned so that 2^31 survives
            ST_CU1: begin ma = 34'($unsigned(t_reg)); mb = 34'($unsigned(t_reg)); end
            ST_CU2: begin ma = 34'(acc_reg[31:0]); mb = 34'($unsigned(t_reg)); end
            ST_CU3: begin ma = 34'(acc_reg[31:0]); mb = 34'(inv_sample_rate); end
            default: ;
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (job_valid) state_next = job.upd ? ST_C_R : ST_SMOOTH;
            ST_C_R:   state_next = ST_C_X;
            ST_C_X:   state_next = ST_C_X2;
            ST_C_X2:  state_next = ST_C_X3;
            ST_C_X3:  state_next = ST_C_S;
            ST_C_S:   state_next = ST_C_QC1;
            ST_C_QC1: state_next = ST_C_QC2;
            ST_C_QC2: state_next = ST_SMOOTH;
            ST_SMOOTH: state_next = ST_L1;
            ST_L1: state_next = ST_D1;
            ST_D1: state_next = ST_H1;
            ST_H1: state_next = ST_B1;
            ST_B1: state_next = ST_L2;
            ST_L2: state_next = ST_D2;
            ST_D2: state_next = ST_H2;
            ST_H2: state_next = ST_B2;
            ST_B2: state_next = ST_CU1;
            ST_CU1: state_next = ST_CU2;
            ST_CU2: state_next = ST_CU3;
            ST_CU3: state_next = ST_CU4;
            ST_CU4: state_next = ST_OUT;
            ST_OUT: if (!out_v_reg) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            out_v_reg <= 1'b0;
            l_reg <= '0; b_reg <= '0; m_reg <= '0;
            f_reg <= '0; d_reg <= '0; qc_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (pop && out_v_reg)
                out_v_reg <= 1'b0;
            unique case (state_reg)
                ST_C_R:
                begin
                    acc_reg <= (pu >> 2) > 64'h4000_0000 ? 64'h4000_0000 : pu >> 2;
                    d_reg   <= lq[17:0];
                end
                ST_C_X:  begin x_reg <= 32'(pu >> 30); end
                ST_C_X2: acc_reg <= pu >> 30;
                ST_C_X3: acc_reg <= pu >> 30;
                // x - x^3/6, the divide by reciprocal multiplication
                ST_C_S:  f_reg <= 18'((x_reg - 32'(pu >> 34)) >> 13);
                ST_C_QC1: acc_reg <= pu;
                ST_C_QC2: qc_reg <= (pu >> 32) > 64'(COEF_MAX) ? 18'(COEF_MAX)
                                                              : 18'(pu >> 32);
                ST_SMOOTH: m_reg <= sat32(48'(m_reg) + 48'(prod >>> 16));
                ST_L1, ST_L2: l_reg <= sat32(48'(l_reg) + 48'(prod >>> 16));
                ST_D1, ST_D2: h_reg <= 32'(prod >>> 16 > 68'sh7FFF_FFFF ? 68'sh7FFF_FFFF
                                      : prod >>> 16 < -68'sh8000_0000 ? -68'sh8000_0000
                                      : prod >>> 16);
                ST_H1, ST_H2: h_reg <= sat32(48'(m_reg) - 48'(l_reg) - 48'(h_reg));
                ST_B1: b_reg <= b_new;
                ST_B2:
                begin
                    b_reg   <= b_new;
                    neg_reg <= b_new < 0;
                    t_reg   <= b_new < 0 ? -b_new : b_new;
                end
                ST_CU1: acc_reg <= (pu >> 28) > 64'hFFFF_FFFF ? 64'hFFFF_FFFF : pu >> 28;
                ST_CU2: acc_reg <= (pu >> 28) > 64'h7FFF_FFFF ? 64'h7FFF_FFFF : pu >> 28;
                ST_CU3: acc_reg <= pu >> 30;
                ST_CU4:
                begin
                    b_reg <= neg_reg ? sat32(48'(b_reg) + 48'(acc_reg[33:0]))
                                     : sat32(48'(b_reg) - 48'(acc_reg[33:0]));
                end
                ST_OUT:
                begin
                    if (!out_v_reg)
                    begin
                        out_v_reg <= 1'b1;
                        out_reg <= y_sh > 48'sd8388607 ? 24'sh7FFFFF
                                 : y_sh < -48'sd8388608 ? 24'sh800000 : y_sh[23:0];
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

/* src/oversampled_state_variable_filter.sv */
// The back works on one word at a time, from the queue into the sequencer; a refresh of
// coefficients (every word when unmodulated) adds the coefficient states. The pace is
// set by the single shared multiplier and the sequenced filter steps.
// A two-word queue between the front and the back accepts words while one works.
// Reset (rst_n low, asynchronous) clears all filter state, coefficients and the
// update phase; registers return to mode 0, 48 kHz and its reciprocal.
module oversampled_state_variable_filter
    import osvf_pkg::*;
#(
    parameter int UPDATE_INTERVAL_LOG2 = 4
)(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic signed [AUDIO_W-1:0] audio_in,
    input  logic [FC_W-1:0]           cutoff_in,
    input  logic signed [Q_W-1:0]     resonance_in,
    output logic                      empty,
    input  logic                      pop,
    output logic signed [AUDIO_W-1:0] audio_out,
    input  logic                      cfg_we,
    input  logic [2:0]                cfg_index,
    input  logic [31:0]               cfg_data
);

    logic [1:0]            mode_reg;
    logic [FC_W-1:0]       cutoff_reg;
    logic signed [Q_W-1:0] res_reg;
    logic                  fc_in_reg, q_in_reg;
    logic [17:0]           sr_reg;
    logic [31:0]           inv_reg;
    logic                  job_valid, job_take;
    job_t                  job;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= '0; cutoff_reg <= '0; res_reg <= '0;
            fc_in_reg <= 1'b0; q_in_reg <= 1'b0;
            sr_reg <= 18'd48000; inv_reg <= 32'd89478;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MODE:   mode_reg   <= cfg_data[1:0];
                CFG_CUTOFF: cutoff_reg <= cfg_data[FC_W-1:0];
                CFG_RES:    res_reg    <= cfg_data[Q_W-1:0];
                CFG_FC_IN:  fc_in_reg  <= cfg_data[0];
                CFG_Q_IN:   q_in_reg   <= cfg_data[0];
                CFG_SR:     sr_reg     <= cfg_data[17:0];
                CFG_INV_SR: inv_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    osvf_front #(.UPD_LOG2(UPDATE_INTERVAL_LOG2)) u_front (
        .clk, .rst_n, .push, .full, .audio_in, .cutoff_in, .resonance_in,
        .modulated(fc_in_reg || q_in_reg), .job_valid, .job, .job_take
    );

    osvf_back u_back (
        .clk, .rst_n, .job_valid, .job, .job_take,
        .filter_mode(mode_reg), .cutoff_hz(cutoff_reg), .resonance(res_reg),
        .cutoff_from_input(fc_in_reg), .resonance_from_input(q_in_reg),
        .sample_rate_hz(sr_reg), .inv_sample_rate(inv_reg),
        .empty, .pop, .audio_out
    );

    a_no_take_empty: assert property (@(posedge clk) disable iff (!rst_n)
        job_take |-> job_valid) else $error("back took from empty queue");
    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (full && !job_take) |=> full) else $error("queue lost a word");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(audio_out)))
        else $error("result changed while waiting");

endmodule
